### design/sic_pkg.sv
// sic_pkg: shared codes for the segment intersection classifier
// opcodes, point classes and orientation codes; no dependencies
package sic_pkg;

    // operation select
    typedef enum logic {
        OP_CLASSIFY  = 1'b0,
        OP_INTERSECT = 1'b1
    } opcode_t;

    // position of a point against a directed segment
    typedef enum logic [2:0] {
        CLS_LEFT    = 3'd0,
        CLS_RIGHT   = 3'd1,
        CLS_BEHIND  = 3'd2,
        CLS_BEYOND  = 3'd3,
        CLS_ORIGIN  = 3'd4,
        CLS_DEST    = 3'd5,
        CLS_BETWEEN = 3'd6
    } pclass_t;

    // relation between the two segments
    typedef enum logic [1:0] {
        ORI_COLLINEAR = 2'd0,
        ORI_PARALLEL  = 2'd1,
        ORI_CROSS     = 2'd2,
        ORI_APART     = 2'd3
    } orient_t;

endpackage

### design/sic_divider.sv
// sic_divider: pipelined restoring divider, one quotient bit per stage
// unsigned num / den, quotient known to fit QW bits; no package needed
module sic_divider #(
    parameter int NW  = 70,
    parameter int DVW = 35,
    parameter int QW  = 34
) (
    input  logic           clk,
    input  logic           en,
    input  logic [NW-1:0]  num,
    input  logic [DVW-1:0] den,
    output logic [QW-1:0]  quo,
    output logic           rem_nz
);

    logic [DVW-1:0] r_reg [QW];
    logic [QW-1:0]  n_reg [QW];
    logic [QW-1:0]  q_reg [QW];
    logic [DVW-1:0] d_reg [QW];

    for (genvar k = 0; k < QW; k++)
    begin : g_stage
        logic [DVW-1:0] r_prev;
        logic [QW-1:0]  n_prev;
        logic [QW-1:0]  q_prev;
        logic [DVW-1:0] d_prev;
        logic [DVW:0]   r_sh;
        logic [DVW:0]   r_sub;
        logic           ge;

        // stage inputs: the request itself for the first stage
        if (k == 0)
        begin : g_first
            assign r_prev = num[NW-1:QW];
            assign n_prev = num[QW-1:0];
            assign q_prev = '0;
            assign d_prev = den;
        end
        else
        begin : g_rest
            assign r_prev = r_reg[k-1];
            assign n_prev = n_reg[k-1];
            assign q_prev = q_reg[k-1];
            assign d_prev = d_reg[k-1];
        end

        // bring down one numerator bit, trial subtract
        assign r_sh  = {r_prev, n_prev[QW-1-k]};
        assign r_sub = r_sh - {1'b0, d_prev};
        assign ge    = (r_sh >= {1'b0, d_prev});

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                r_reg[k] <= ge ? r_sub[DVW-1:0] : r_sh[DVW-1:0];
                n_reg[k] <= n_prev;
                q_reg[k] <= {q_prev[QW-2:0], ge};
                d_reg[k] <= d_prev;
            end
        end
    end

    assign quo    = q_reg[QW-1];
    assign rem_nz = (r_reg[QW-1] != '0);

endmodule

### design/segment_intersection_classifier.sv
// Throughput: one request per cycle; the whole pipeline holds while a result is stalled.
// Depth is set by the crossing-point divider, which resolves one quotient bit per stage.
// Reset clears only the stage valid bits; data registers are not reset.
// Uses sic_pkg and sic_divider (two instances, x and y).
module segment_intersection_classifier
    import sic_pkg::*;
#(
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic                         opcode,
    input  logic signed [COORD_BITS-1:0] first_start_x,
    input  logic signed [COORD_BITS-1:0] first_start_y,
    input  logic signed [COORD_BITS-1:0] first_end_x,
    input  logic signed [COORD_BITS-1:0] first_end_y,
    input  logic signed [COORD_BITS-1:0] second_start_x,
    input  logic signed [COORD_BITS-1:0] second_start_y,
    input  logic signed [COORD_BITS-1:0] second_end_x,
    input  logic signed [COORD_BITS-1:0] second_end_y,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [2:0]                   point_class,
    output logic [1:0]                   orientation_code,
    output logic signed [31:0]           cross_x,
    output logic signed [31:0]           cross_y
);

    localparam int C    = COORD_BITS;
    localparam int F    = FRAC_BITS;
    localparam int DW   = C + 1;
    localparam int PW   = 2 * C + 2;
    localparam int SW   = 2 * C + 3;
    localparam int UW   = 2 * C + 2;
    localparam int MW   = C + 1;
    localparam int PRW  = UW + MW;
    localparam int NW   = PRW + F + 2;
    localparam int QW   = C + F + 2;
    localparam int DVW  = UW + 1;
    localparam int VW   = (C + F + 3 > 33) ? C + F + 3 : 33;
    localparam int NST  = QW + 10;
    localparam logic signed [VW-1:0] SAT_HI = VW'(64'sh7FFF_FFFF);
    localparam logic signed [VW-1:0] SAT_LO = VW'(-64'sh8000_0000);

    typedef struct packed {
        opcode_t               op;
        logic signed [C-1:0]   x0;
        logic signed [C-1:0]   y0;
        logic signed [C-1:0]   x1;
        logic signed [C-1:0]   y1;
        logic signed [C-1:0]   x2;
        logic signed [C-1:0]   y2;
        logic signed [C-1:0]   x3;
        logic signed [C-1:0]   y3;
        logic signed [DW-1:0]  ax;
        logic signed [DW-1:0]  ay;
        logic                  behind;
        logic                  origin;
        logic                  dest;
    } geo_t;

    typedef struct packed {
        logic                  neg_x;
        logic                  neg_y;
        logic                  zero;
        logic signed [C-1:0]   base_x;
        logic signed [C-1:0]   base_y;
        pclass_t               pclass;
        orient_t               ocode;
    } side_t;

    logic             adv;
    logic [NST-1:0]   vld_reg;

    // stage a: differences
    geo_t                 a_geo_reg;
    logic signed [DW-1:0] a_bx_reg, a_by_reg, a_dx_reg, a_dy_reg;
    // stage b: products
    geo_t                 b_geo_reg, b_geo_next;
    logic signed [PW-1:0] b_axby_reg, b_aybx_reg, b_aydx_reg, b_axdy_reg;
    logic signed [PW-1:0] b_dybx_reg, b_dxby_reg;
    logic signed [PW-1:0] b_axax_reg, b_ayay_reg, b_bxbx_reg, b_byby_reg;
    // stage c: sums
    geo_t                 c_geo_reg;
    logic signed [SW-1:0] c_cross_reg, c_den_reg, c_tn_reg, c_na_reg, c_nb_reg;
    // stage d: class and normalised fractions
    geo_t                 d_geo_reg;
    pclass_t              d_pclass_reg, d_pclass_next;
    logic                 d_den_zero_reg, d_cross_nz_reg;
    logic signed [SW-1:0] d_sn_reg, d_tn_reg, d_td_reg;
    // stage e: decision
    side_t                e_side_reg, e_side_next;
    logic [UW-1:0]        e_tn_reg, e_td_reg;
    logic [MW-1:0]        e_magx_reg, e_magy_reg;
    logic                 not_cross;
    // stage f: scale products
    side_t                f_side_reg;
    logic [PRW-1:0]       f_px_reg, f_py_reg;
    logic [UW-1:0]        f_td_reg;
    // stage g: rounding offset candidates
    side_t                g_side_reg;
    logic [NW-1:0]        g_ax_reg, g_ay_reg;
    logic signed [NW:0]   g_bx_reg, g_by_reg;
    logic [UW-1:0]        g_td_reg;
    // stage h: divider operands
    side_t                h_side_reg, h_side_next;
    logic [NW-1:0]        h_magx_reg, h_magy_reg, h_magx_next, h_magy_next;
    logic [DVW-1:0]       h_den_reg;
    // divider sideband and outputs
    side_t                sd_reg [QW];
    logic [QW-1:0]        quo_x, quo_y;
    logic                 rnz_x, rnz_y;
    // fix stage: signed quotient
    side_t                i_side_reg;
    logic signed [QW:0]   i_qsx_reg, i_qsy_reg, i_qsx_next, i_qsy_next;
    // output stage
    logic signed [VW-1:0] vx, vy;
    logic [2:0]           o_pclass_reg;
    logic [1:0]           o_ocode_reg;
    logic signed [31:0]   o_cx_reg, o_cy_reg;

    // global advance: hold everything while the result is stalled
    assign adv      = !(vld_reg[NST-1] && out_stall);
    assign in_stall = !adv;

    // valid bits travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[NST-2:0], in_valid};
        end
    end

    // stage b flags from differences
    always_comb
    begin
        b_geo_next        = a_geo_reg;
        b_geo_next.behind = (a_geo_reg.ax < 0 && a_bx_reg > 0) ||
                            (a_geo_reg.ax > 0 && a_bx_reg < 0) ||
                            (a_geo_reg.ay < 0 && a_by_reg > 0) ||
                            (a_geo_reg.ay > 0 && a_by_reg < 0);
        b_geo_next.origin = (a_bx_reg == 0) && (a_by_reg == 0);
    end

    // stage d classification
    always_comb
    begin
        if (c_cross_reg > 0)
            d_pclass_next = CLS_LEFT;
        else if (c_cross_reg < 0)
            d_pclass_next = CLS_RIGHT;
        else if (c_geo_reg.behind)
            d_pclass_next = CLS_BEHIND;
        else if (c_na_reg < c_nb_reg)
            d_pclass_next = CLS_BEYOND;
        else if (c_geo_reg.origin)
            d_pclass_next = CLS_ORIGIN;
        else if (c_geo_reg.dest)
            d_pclass_next = CLS_DEST;
        else
            d_pclass_next = CLS_BETWEEN;
    end

    // stage e crossing decision and snapping
    assign not_cross = (d_sn_reg < 0) || (d_sn_reg > d_td_reg) ||
                       (d_tn_reg < 0) || (d_tn_reg > d_td_reg);

    always_comb
    begin
        e_side_next        = '0;
        e_side_next.neg_x  = (d_geo_reg.ax < 0);
        e_side_next.neg_y  = (d_geo_reg.ay < 0);
        e_side_next.zero   = 1'b1;
        e_side_next.pclass = CLS_LEFT;
        e_side_next.ocode  = ORI_COLLINEAR;
        if (d_geo_reg.op == OP_CLASSIFY)
        begin
            e_side_next.pclass = d_pclass_reg;
        end
        else if (d_den_zero_reg)
        begin
            e_side_next.ocode = d_cross_nz_reg ? ORI_PARALLEL : ORI_COLLINEAR;
        end
        else if (not_cross)
        begin
            e_side_next.ocode = ORI_APART;
        end
        else
        begin
            e_side_next.ocode = ORI_CROSS;
            if (d_tn_reg == 0)
            begin
                e_side_next.base_x = d_geo_reg.x2;
                e_side_next.base_y = d_geo_reg.y2;
            end
            else if (d_tn_reg == d_td_reg)
            begin
                e_side_next.base_x = d_geo_reg.x3;
                e_side_next.base_y = d_geo_reg.y3;
            end
            else if (d_sn_reg == 0)
            begin
                e_side_next.base_x = d_geo_reg.x0;
                e_side_next.base_y = d_geo_reg.y0;
            end
            else if (d_sn_reg == d_td_reg)
            begin
                e_side_next.base_x = d_geo_reg.x1;
                e_side_next.base_y = d_geo_reg.y1;
            end
            else
            begin
                e_side_next.base_x = d_geo_reg.x2;
                e_side_next.base_y = d_geo_reg.y2;
                e_side_next.zero   = 1'b0;
            end
        end
    end

    // stage h: magnitude of the signed numerator and its sign
    always_comb
    begin
        h_side_next       = g_side_reg;
        h_side_next.neg_x = 1'b0;
        h_side_next.neg_y = 1'b0;
        if (!g_side_reg.neg_x)
            h_magx_next = g_ax_reg;
        else if (g_bx_reg > 0)
        begin
            h_magx_next       = g_bx_reg[NW-1:0];
            h_side_next.neg_x = 1'b1;
        end
        else
            h_magx_next = NW'(-g_bx_reg);
        if (!g_side_reg.neg_y)
            h_magy_next = g_ay_reg;
        else if (g_by_reg > 0)
        begin
            h_magy_next       = g_by_reg[NW-1:0];
            h_side_next.neg_y = 1'b1;
        end
        else
            h_magy_next = NW'(-g_by_reg);
    end

    // fix stage: floor quotient of a negative numerator, zero offset for a snapped point
    always_comb
    begin
        i_qsx_next = $signed({1'b0, quo_x});
        i_qsy_next = $signed({1'b0, quo_y});
        if (sd_reg[QW-1].neg_x)
            i_qsx_next = $signed(~{1'b0, quo_x}) + $signed((QW+1)'(!rnz_x));
        if (sd_reg[QW-1].neg_y)
            i_qsy_next = $signed(~{1'b0, quo_y}) + $signed((QW+1)'(!rnz_y));
        if (sd_reg[QW-1].zero)
        begin
            i_qsx_next = '0;
            i_qsy_next = '0;
        end
    end

    // output stage: base plus offset
    assign vx = (VW'(i_side_reg.base_x) <<< F) + VW'(i_qsx_reg);
    assign vy = (VW'(i_side_reg.base_y) <<< F) + VW'(i_qsy_reg);

    // data pipeline
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // stage a
            a_geo_reg.op     <= opcode_t'(opcode);
            a_geo_reg.x0     <= first_start_x;
            a_geo_reg.y0     <= first_start_y;
            a_geo_reg.x1     <= first_end_x;
            a_geo_reg.y1     <= first_end_y;
            a_geo_reg.x2     <= second_start_x;
            a_geo_reg.y2     <= second_start_y;
            a_geo_reg.x3     <= second_end_x;
            a_geo_reg.y3     <= second_end_y;
            a_geo_reg.ax     <= DW'(second_end_x) - DW'(second_start_x);
            a_geo_reg.ay     <= DW'(second_end_y) - DW'(second_start_y);
            a_geo_reg.behind <= 1'b0;
            a_geo_reg.origin <= 1'b0;
            a_geo_reg.dest   <= (first_start_x == second_end_x) &&
                                (first_start_y == second_end_y);
            a_bx_reg <= DW'(first_start_x) - DW'(second_start_x);
            a_by_reg <= DW'(first_start_y) - DW'(second_start_y);
            a_dx_reg <= DW'(first_end_x) - DW'(first_start_x);
            a_dy_reg <= DW'(first_end_y) - DW'(first_start_y);
            // stage b
            b_geo_reg  <= b_geo_next;
            b_axby_reg <= a_geo_reg.ax * a_by_reg;
            b_aybx_reg <= a_geo_reg.ay * a_bx_reg;
            b_aydx_reg <= a_geo_reg.ay * a_dx_reg;
            b_axdy_reg <= a_geo_reg.ax * a_dy_reg;
            b_dybx_reg <= a_dy_reg * a_bx_reg;
            b_dxby_reg <= a_dx_reg * a_by_reg;
            b_axax_reg <= a_geo_reg.ax * a_geo_reg.ax;
            b_ayay_reg <= a_geo_reg.ay * a_geo_reg.ay;
            b_bxbx_reg <= a_bx_reg * a_bx_reg;
            b_byby_reg <= a_by_reg * a_by_reg;
            // stage c
            c_geo_reg   <= b_geo_reg;
            c_cross_reg <= SW'(b_axby_reg) - SW'(b_aybx_reg);
            c_den_reg   <= SW'(b_aydx_reg) - SW'(b_axdy_reg);
            c_tn_reg    <= SW'(b_dybx_reg) - SW'(b_dxby_reg);
            c_na_reg    <= SW'(b_axax_reg) + SW'(b_ayay_reg);
            c_nb_reg    <= SW'(b_bxbx_reg) + SW'(b_byby_reg);
            // stage d
            d_geo_reg      <= c_geo_reg;
            d_pclass_reg   <= d_pclass_next;
            d_den_zero_reg <= (c_den_reg == 0);
            d_cross_nz_reg <= (c_cross_reg != 0);
            d_sn_reg       <= (c_den_reg < 0) ? -c_cross_reg : c_cross_reg;
            d_tn_reg       <= (c_den_reg > 0) ? -c_tn_reg : c_tn_reg;
            d_td_reg       <= (c_den_reg < 0) ? -c_den_reg : c_den_reg;
            // stage e
            e_side_reg <= e_side_next;
            e_tn_reg   <= UW'(d_tn_reg);
            e_td_reg   <= UW'(d_td_reg);
            e_magx_reg <= MW'((d_geo_reg.ax < 0) ? -d_geo_reg.ax : d_geo_reg.ax);
            e_magy_reg <= MW'((d_geo_reg.ay < 0) ? -d_geo_reg.ay : d_geo_reg.ay);
            // stage f
            f_side_reg <= e_side_reg;
            f_px_reg   <= PRW'(e_tn_reg) * PRW'(e_magx_reg);
            f_py_reg   <= PRW'(e_tn_reg) * PRW'(e_magy_reg);
            f_td_reg   <= e_td_reg;
            // stage g
            g_side_reg <= f_side_reg;
            g_td_reg   <= f_td_reg;
            g_ax_reg   <= {1'b0, f_px_reg, {(F+1){1'b0}}} + NW'(f_td_reg);
            g_ay_reg   <= {1'b0, f_py_reg, {(F+1){1'b0}}} + NW'(f_td_reg);
            g_bx_reg   <= $signed({2'b00, f_px_reg, {(F+1){1'b0}}}) -
                          $signed((NW+1)'(f_td_reg));
            g_by_reg   <= $signed({2'b00, f_py_reg, {(F+1){1'b0}}}) -
                          $signed((NW+1)'(f_td_reg));
            // stage h
            h_side_reg <= h_side_next;
            h_magx_reg <= h_magx_next;
            h_magy_reg <= h_magy_next;
            h_den_reg  <= {g_td_reg, 1'b0};
            // sideband alongside the divider
            sd_reg[0] <= h_side_reg;
            for (int k = 1; k < QW; k++)
                sd_reg[k] <= sd_reg[k-1];
            // fix stage
            i_side_reg <= sd_reg[QW-1];
            i_qsx_reg  <= i_qsx_next;
            i_qsy_reg  <= i_qsy_next;
            // output stage with saturation
            o_pclass_reg <= i_side_reg.pclass;
            o_ocode_reg  <= i_side_reg.ocode;
            o_cx_reg <= (vx > SAT_HI) ? 32'sh7FFF_FFFF :
                        (vx < SAT_LO) ? -32'sh7FFF_FFFF - 32'sd1 : vx[31:0];
            o_cy_reg <= (vy > SAT_HI) ? 32'sh7FFF_FFFF :
                        (vy < SAT_LO) ? -32'sh7FFF_FFFF - 32'sd1 : vy[31:0];
        end
    end

    // crossing point dividers, x and y
    sic_divider #(
        .NW  (NW),
        .DVW (DVW),
        .QW  (QW)
    ) u_div_x (
        .clk    (clk),
        .en     (adv),
        .num    (h_magx_reg),
        .den    (h_den_reg),
        .quo    (quo_x),
        .rem_nz (rnz_x)
    );

    sic_divider #(
        .NW  (NW),
        .DVW (DVW),
        .QW  (QW)
    ) u_div_y (
        .clk    (clk),
        .en     (adv),
        .num    (h_magy_reg),
        .den    (h_den_reg),
        .quo    (quo_y),
        .rem_nz (rnz_y)
    );

    assign out_valid        = vld_reg[NST-1];
    assign point_class      = o_pclass_reg;
    assign orientation_code = o_ocode_reg;
    assign cross_x          = o_cx_reg;
    assign cross_y          = o_cy_reg;

    // coordinates only for a crossing
    a_coord_only_cross: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && orientation_code != ORI_CROSS |-> cross_x == 0 && cross_y == 0)
        else $error("crossing point set without a crossing");

    // the two result kinds are exclusive
    a_mode_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && point_class != CLS_LEFT |-> orientation_code == ORI_COLLINEAR)
        else $error("point class and orientation both set");

    // a stalled result freezes the pipeline
    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(vld_reg))
        else $error("pipeline moved under stall");

    // an accepted request enters the first stage
    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> vld_reg[0])
        else $error("accepted request lost");

endmodule

### verif/sic_checker.sv
// sic_checker: watches both channels of the segment intersection classifier,
// predicts each result from the accepted request and compares field by field
// depends on sic_pkg for the opcode, point class and orientation codes
module sic_checker
    import sic_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic               opcode,
    input  logic signed [15:0] first_start_x,
    input  logic signed [15:0] first_start_y,
    input  logic signed [15:0] first_end_x,
    input  logic signed [15:0] first_end_y,
    input  logic signed [15:0] second_start_x,
    input  logic signed [15:0] second_start_y,
    input  logic signed [15:0] second_end_x,
    input  logic signed [15:0] second_end_y,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic [2:0]         point_class,
    input  logic [1:0]         orientation_code,
    input  logic signed [31:0] cross_x,
    input  logic signed [31:0] cross_y,
    output int                 errors,
    output int                 pending,
    output int                 crossings
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC = 16;

    typedef struct packed {
        pclass_t            pc;
        orient_t            oc;
        logic signed [31:0] cx;
        logic signed [31:0] cy;
    } geom_result_t;

    geom_result_t expected_q[$];

    // position of point p against the directed segment s -> e
    function automatic pclass_t locate_point(longint px, longint py, longint sx, longint sy,
                                             longint ex, longint ey);
        longint ax, ay, bx, by, c;
        ax = ex - sx;
        ay = ey - sy;
        bx = px - sx;
        by = py - sy;
        c = ax * by - bx * ay;
        if (c > 0) return CLS_LEFT;
        if (c < 0) return CLS_RIGHT;
        if ((ax < 0 && bx > 0) || (ax > 0 && bx < 0) || (ay < 0 && by > 0) || (ay > 0 && by < 0))
            return CLS_BEHIND;
        if (ax * ax + ay * ay < bx * bx + by * by) return CLS_BEYOND;
        if (bx == 0 && by == 0) return CLS_ORIGIN;
        if (px == ex && py == ey) return CLS_DEST;
        return CLS_BETWEEN;
    endfunction

    function automatic logic signed [31:0] clamp32(logic signed [127:0] v);
        if (v > 128'sd2147483647) return 32'sh7fffffff;
        if (v < -128'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    // base + delta*tn/td in fixed point, nearest with ties upward
    function automatic logic signed [31:0] lerp_fixed(longint base, longint delta,
                                                      longint tn, longint td);
        logic signed [127:0] num, div, q;
        num = 128'(tn) * 128'(delta) * (128'sd1 <<< (FRAC + 1)) + 128'(td);
        div = 128'(td) * 2;
        q = num / div;
        if (num < 0 && q * div != num) q = q - 1;
        return clamp32(128'(base) * (128'sd1 <<< FRAC) + q);
    endfunction

    function automatic geom_result_t predict_geometry(logic op, longint x0, longint y0,
                                                      longint x1, longint y1, longint x2,
                                                      longint y2, longint x3, longint y3);
        geom_result_t r;
        longint nx, ny, mx, my, den, sn, sd, tn, td;
        r = '{pc: CLS_LEFT, oc: ORI_COLLINEAR, cx: '0, cy: '0};
        if (op == OP_CLASSIFY) begin
            r.pc = locate_point(x0, y0, x2, y2, x3, y3);
            return r;
        end
        nx = y3 - y2;
        ny = x2 - x3;
        den = nx * (x1 - x0) + ny * (y1 - y0);
        // zero denominator: parallel unless the start lies on the reference line
        if (den == 0) begin
            r.oc = (locate_point(x0, y0, x2, y2, x3, y3) inside {CLS_LEFT, CLS_RIGHT})
                   ? ORI_PARALLEL : ORI_COLLINEAR;
            return r;
        end
        mx = y1 - y0;
        my = x0 - x1;
        sn = -(nx * (x0 - x2) + ny * (y0 - y2));
        sd = den;
        tn = -(mx * (x2 - x0) + my * (y2 - y0));
        td = mx * (x3 - x2) + my * (y3 - y2);
        if (sd < 0) begin
            sd = -sd;
            sn = -sn;
        end
        if (td < 0) begin
            td = -td;
            tn = -tn;
        end
        if (sn < 0 || sn > sd || td == 0 || tn < 0 || tn > td) begin
            r.oc = ORI_APART;
            return r;
        end
        r.oc = ORI_CROSS;
        // endpoint snapping, reference segment first
        if (tn == 0) begin
            r.cx = 32'(x2 * 65536);
            r.cy = 32'(y2 * 65536);
        end else if (tn == td) begin
            r.cx = 32'(x3 * 65536);
            r.cy = 32'(y3 * 65536);
        end else if (sn == 0) begin
            r.cx = 32'(x0 * 65536);
            r.cy = 32'(y0 * 65536);
        end else if (sn == sd) begin
            r.cx = 32'(x1 * 65536);
            r.cy = 32'(y1 * 65536);
        end else begin
            r.cx = lerp_fixed(x2, x3 - x2, tn, td);
            r.cy = lerp_fixed(y2, y3 - y2, tn, td);
        end
        return r;
    endfunction

    // predict on each accepted request, compare on each accepted result
    always @(posedge clk or negedge rst_n) begin
        geom_result_t exp_r;
        if (!rst_n) begin
            expected_q.delete();
            errors    <= 0;
            pending   <= 0;
            crossings <= 0;
        end else begin
            if (in_valid && !in_stall) begin
                exp_r = predict_geometry(opcode, first_start_x, first_start_y, first_end_x,
                                         first_end_y, second_start_x, second_start_y,
                                         second_end_x, second_end_y);
                if (exp_r.oc == ORI_CROSS) crossings <= crossings + 1;
                expected_q.push_back(exp_r);
            end
            if (out_valid && !out_stall) begin
                if (expected_q.size() == 0) begin
                    $error("result with nothing expected");
                    errors <= errors + 1;
                end else begin
                    exp_r = expected_q.pop_front();
                    if (point_class !== exp_r.pc || orientation_code !== exp_r.oc ||
                        cross_x !== exp_r.cx || cross_y !== exp_r.cy) begin
                        errors <= errors + 1;
                        if (point_class !== exp_r.pc)
                            $error("point_class expected %0d got %0d", exp_r.pc, point_class);
                        if (orientation_code !== exp_r.oc)
                            $error("orientation_code expected %0d got %0d", exp_r.oc,
                                   orientation_code);
                        if (cross_x !== exp_r.cx)
                            $error("cross_x expected %0d got %0d", exp_r.cx, cross_x);
                        if (cross_y !== exp_r.cy)
                            $error("cross_y expected %0d got %0d", exp_r.cy, cross_y);
                    end
                end
            end
            pending <= expected_q.size();
        end
    end

endmodule

### verif/testbench.sv
// testbench: drives random and directed segment pairs into the classifier
// with random idle and stall bursts; depends on sic_pkg, sic_checker and the RTL
module testbench
    import sic_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_RANDOM = 1430;
    localparam int CYCLE_LIMIT = 300000;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic               opcode = 1'b0;
    logic signed [15:0] fsx = '0, fsy = '0, fex = '0, fey = '0;
    logic signed [15:0] ssx = '0, ssy = '0, sex = '0, sey = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [2:0]         point_class;
    logic [1:0]         orientation_code;
    logic signed [31:0] cross_x, cross_y;
    int                 errors, pending, crossings;
    int                 cycles = 0;
    int                 n_classify = 0, n_intersect = 0;
    bit                 quiet = 1'b0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    segment_intersection_classifier u_dut (
        .clk, .rst_n, .in_valid, .in_stall, .opcode,
        .first_start_x(fsx), .first_start_y(fsy), .first_end_x(fex), .first_end_y(fey),
        .second_start_x(ssx), .second_start_y(ssy), .second_end_x(sex), .second_end_y(sey),
        .out_valid, .out_stall, .point_class, .orientation_code, .cross_x, .cross_y
    );

    sic_checker u_checker (
        .clk, .rst_n, .in_valid, .in_stall, .opcode,
        .first_start_x(fsx), .first_start_y(fsy), .first_end_x(fex), .first_end_y(fey),
        .second_start_x(ssx), .second_start_y(ssy), .second_end_x(sex), .second_end_y(sey),
        .out_valid, .out_stall, .point_class, .orientation_code, .cross_x, .cross_y,
        .errors, .pending, .crossings
    );

    // run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // result side stalls in bursts, none once quiet
    initial
    begin
        @(posedge rst_n);
        while (1) begin
            @(posedge clk);
            if (!quiet && $urandom_range(0, 5) == 0) begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 17)) @(posedge clk);
                out_stall <= 1'b0;
                repeat ($urandom_range(0, 20)) @(posedge clk);
            end
        end
    end

    // present one request and hold it until the block takes it
    task automatic send_segments(logic op, logic signed [15:0] x0, y0, x1, y1,
                                 logic signed [15:0] x2, y2, x3, y3);
        if (!quiet && $urandom_range(0, 7) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        in_valid <= 1'b1;
        opcode   <= op;
        fsx <= x0; fsy <= y0; fex <= x1; fey <= y1;
        ssx <= x2; ssy <= y2; sex <= x3; sey <= y3;
        if (op == OP_CLASSIFY) n_classify++;
        else n_intersect++;
        do @(negedge clk); while (in_stall);
        @(posedge clk);
    endtask

    // coordinate from a small window near the origin, or anywhere
    function automatic logic signed [15:0] pick_coord(bit wide);
        if (wide) return 16'($urandom);
        return 16'($urandom_range(0, 12)) - 16'sd6;
    endfunction

    initial
    begin
        logic op;
        bit   wide;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: every point class
        send_segments(OP_CLASSIFY, 0, 5, 0, 0, 0, 0, 10, 0);       // left
        send_segments(OP_CLASSIFY, 0, -5, 0, 0, 0, 0, 10, 0);      // right
        send_segments(OP_CLASSIFY, -3, 0, 0, 0, 0, 0, 10, 0);      // behind
        send_segments(OP_CLASSIFY, 13, 0, 0, 0, 0, 0, 10, 0);      // beyond
        send_segments(OP_CLASSIFY, 0, 0, 1, 1, 0, 0, 10, 0);       // origin
        send_segments(OP_CLASSIFY, 10, 0, 1, 1, 0, 0, 10, 0);      // destination
        send_segments(OP_CLASSIFY, 4, 0, 1, 1, 0, 0, 10, 0);       // between
        send_segments(OP_CLASSIFY, 3, 3, 0, 0, 2, 2, 2, 2);        // degenerate reference
        send_segments(OP_CLASSIFY, 2, 2, 0, 0, 2, 2, 2, 2);        // degenerate, on start
        // directed: extremes of the coordinate range
        send_segments(OP_CLASSIFY, 16'sh7fff, 16'sh8000, 0, 0,
                      16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000);
        send_segments(OP_INTERSECT, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff,
                      16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000);
        send_segments(OP_INTERSECT, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7ffe,
                      16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8001);
        // directed: every orientation
        send_segments(OP_INTERSECT, 0, 0, 4, 0, 1, 0, 7, 0);       // collinear
        send_segments(OP_INTERSECT, 0, 1, 4, 1, 0, 0, 7, 0);       // parallel
        send_segments(OP_INTERSECT, 0, 0, 3, 3, 0, 3, 3, 0);       // crossing inside
        send_segments(OP_INTERSECT, 0, 0, 1, 1, 0, 3, 3, 0);       // apart
        send_segments(OP_INTERSECT, 0, 0, 3, 0, 0, 2, 0, 0);       // at reference end
        send_segments(OP_INTERSECT, 0, 0, 3, 0, 0, 0, 0, 2);       // at reference start
        send_segments(OP_INTERSECT, 1, 0, 3, 0, 1, -2, 1, 2);      // at first start
        send_segments(OP_INTERSECT, -2, 0, 1, 0, 1, -2, 1, 2);     // at first end
        send_segments(OP_INTERSECT, 0, 0, 3, 1, 1, -1, 1, 2);      // rounded point
        send_segments(OP_INTERSECT, 0, 0, -3, -1, 0, 1, 0, -2);    // at first start
        send_segments(OP_INTERSECT, 1, 1, 1, 1, 0, 0, 4, 0);       // degenerate first
        send_segments(OP_INTERSECT, 2, 0, 2, 0, 0, 0, 4, 0);       // degenerate on line

        // random pairs; mostly a small window so ties and touches are common
        for (int i = 0; i < N_RANDOM; i++) begin
            if (i > N_RANDOM - 150) quiet = 1'b1;
            op = $urandom_range(0, 2) != 0;
            wide = $urandom_range(0, 3) == 0;
            send_segments(op, pick_coord(wide), pick_coord(wide), pick_coord(wide),
                          pick_coord(wide), pick_coord(wide), pick_coord(wide),
                          pick_coord(wide), pick_coord(wide));
        end
        in_valid <= 1'b0;

        // drain, then allow for the pipeline depth
        do @(posedge clk); while (pending != 0);
        repeat (60) @(posedge clk);
        $display("covered %0d classify and %0d intersect requests, %0d crossings",
                 n_classify, n_intersect, crossings);
        if (errors == 0 && pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

### sim.f
design/sic_pkg.sv
design/sic_divider.sv
design/segment_intersection_classifier.sv
verif/sic_checker.sv
verif/testbench.sv
